@@ sv/wfpd_pkg.sv @@
// Shared types and constants for the wall-follow PD steering unit.
package wfpd_pkg;

    localparam int DIST_W   = 14;   // signed sensor reading
    localparam int RAW_W    = 13;   // valid reading, always positive
    localparam int GAIN_W   = 16;
    localparam int SPEED_W  = 11;
    localparam int CORR_W   = 7;
    localparam int PD_W     = 9;    // internal PD value, covers +-255
    localparam int MIX_W    = 12;
    localparam int SCALE_SH = 8;    // Q8.8 gains
    localparam int MIN_DIST = 1;
    localparam int MAX_DIST = 300;
    localparam int DEADBAND = 5;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int TDATA_W  = 32;

    typedef enum logic [CFG_AW-1:0] {
        REG_TARGET = 3'd0,
        REG_BASE   = 3'd1,
        REG_INNER  = 3'd2,
        REG_OUTER  = 3'd3,
        REG_KP     = 3'd4,
        REG_KD     = 3'd5,
        REG_KA     = 3'd6,
        REG_MODE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_INNER  = 2'd1,
        MODE_OUTER  = 2'd2
    } steer_mode_t;

    typedef struct packed {
        logic [9:0]        target_distance;
        logic [7:0]        base_speed;
        logic [7:0]        inner_offset;
        logic [7:0]        outer_offset;
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [GAIN_W-1:0] angle_gain;
        logic [2:0]        steer_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_distance: 10'd50,
        base_speed:      8'd100,
        inner_offset:    8'd40,
        outer_offset:    8'd60,
        kp_gain:         16'd768,
        kd_gain:         16'd51,
        angle_gain:      16'd2048,
        steer_mode:      3'd1
    };

endpackage

@@ sv/wall_follow_pd_steering_unit.sv @@
// Top level of the wall-follow PD steering unit: ports, config, mixing, output register.
//
// Takes one front/back distance pair per beat and returns left/right wheel speeds and
// the saturated PD correction. A pair with either reading zero or negative is dropped
// and gives no result. The unit accepts a new pair every cycle while the result side
// does not stall; the history rings keep running sums instead of re-adding the ring.
// An accepted beat passes through the input register, ring/sum update, error, three
// gain multiplies, sum, magnitude, reciprocal divide, round fix-up and speed mix. A
// stall on the result side holds the whole pipeline, so tready follows the output register.
module wall_follow_pd_steering_unit #(
    parameter int HISTORY_LEN = 5,
    parameter int CORRECTION_LIMIT = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [13:0] front_distance, [27:14] back_distance, [31:28] zero
    input  logic [wfpd_pkg::TDATA_W-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [10:0] left_speed, [21:11] right_speed, [28:22] correction, [31:29] zero
    output logic [wfpd_pkg::TDATA_W-1:0]  m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [wfpd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [wfpd_pkg::CFG_DW-1:0]   cfg_wdata
);
    import wfpd_pkg::*;

    localparam int SUM_W = $clog2(HISTORY_LEN * ((1 << RAW_W) - 1) + 1);

    logic                    en;
    cfg_t                    cfg_reg;
    logic signed [DIST_W-1:0] front_in, back_in;
    logic                    pair_ok;
    logic                    s0_valid_reg;
    logic [RAW_W-1:0]        s0_front_reg, s0_back_reg;
    logic                    sum_valid;
    logic [SUM_W-1:0]        front_sum, back_sum;
    logic                    pd_valid;
    logic signed [PD_W-1:0]  pd;
    logic                    out_valid_reg;
    logic [TDATA_W-1:0]      out_data_reg, out_data_next;
    steer_mode_t             mode;
    logic signed [MIX_W-1:0] d_off, u, base, left_s, right_s;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign front_in      = signed'(s_axis_tdata[DIST_W-1:0]);
    assign back_in       = signed'(s_axis_tdata[2*DIST_W-1:DIST_W]);
    assign pair_ok       = !front_in[DIST_W-1] && (|front_in[DIST_W-2:0]) &&
                           !back_in[DIST_W-1] && (|back_in[DIST_W-2:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_TARGET: cfg_reg.target_distance <= cfg_wdata[9:0];
                REG_BASE:   cfg_reg.base_speed      <= cfg_wdata[7:0];
                REG_INNER:  cfg_reg.inner_offset    <= cfg_wdata[7:0];
                REG_OUTER:  cfg_reg.outer_offset    <= cfg_wdata[7:0];
                REG_KP:     cfg_reg.kp_gain         <= cfg_wdata;
                REG_KD:     cfg_reg.kd_gain         <= cfg_wdata;
                REG_KA:     cfg_reg.angle_gain      <= cfg_wdata;
                REG_MODE:   cfg_reg.steer_mode      <= cfg_wdata[2:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= s_axis_tvalid && pair_ok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_front_reg <= RAW_W'(front_in);
            s0_back_reg  <= RAW_W'(back_in);
        end
    end

    wfpd_hist #(
        .HISTORY_LEN (HISTORY_LEN),
        .SUM_W       (SUM_W)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s0_valid_reg),
        .front     (s0_front_reg),
        .back      (s0_back_reg),
        .sum_valid (sum_valid),
        .front_sum (front_sum),
        .back_sum  (back_sum)
    );

    wfpd_pd #(
        .HISTORY_LEN      (HISTORY_LEN),
        .CORRECTION_LIMIT (CORRECTION_LIMIT),
        .SUM_W            (SUM_W)
    ) u_pd (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (sum_valid),
        .front_sum (front_sum),
        .back_sum  (back_sum),
        .pd_valid  (pd_valid),
        .pd        (pd)
    );

    // speed mix by mode and side
    always_comb
    begin
        mode = steer_mode_t'(cfg_reg.steer_mode[2:1]);
        unique case (mode)
            MODE_INNER: d_off = signed'(MIX_W'(cfg_reg.inner_offset));
            MODE_OUTER: d_off = -signed'(MIX_W'(cfg_reg.outer_offset));
            default:    d_off = '0;
        endcase
        u    = d_off + MIX_W'(pd);
        base = signed'(MIX_W'(cfg_reg.base_speed));
        if (cfg_reg.steer_mode[0])
        begin
            left_s  = base - u;
            right_s = base + u;
        end
        else
        begin
            left_s  = base + u;
            right_s = base - u;
        end
        out_data_next = {(TDATA_W - 2 * SPEED_W - CORR_W)'(0), pd[CORR_W-1:0],
                         right_s[SPEED_W-1:0], left_s[SPEED_W-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_drop_bad_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !pair_ok) |=> !s0_valid_reg)
        else $error("rejected pair entered the pipeline");

    a_pd_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pd_valid |-> (pd <= PD_W'(CORRECTION_LIMIT) && pd >= -signed'(PD_W'(CORRECTION_LIMIT))))
        else $error("PD value beyond correction limit");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(pd_valid) && $stable(pd)))
        else $error("pipeline moved during output stall");

endmodule

@@ sv/wfpd_hist.sv @@
// History rings with running front/back sums.
module wfpd_hist #(
    parameter int HISTORY_LEN = 5,
    parameter int SUM_W = $clog2(HISTORY_LEN * ((1 << wfpd_pkg::RAW_W) - 1) + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [wfpd_pkg::RAW_W-1:0] front,
    input  logic [wfpd_pkg::RAW_W-1:0] back,
    output logic                       sum_valid,
    output logic [SUM_W-1:0]           front_sum,
    output logic [SUM_W-1:0]           back_sum
);
    import wfpd_pkg::*;

    localparam int POS_W = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_LEN - 1);

    logic [RAW_W-1:0] front_ring_reg [HISTORY_LEN];
    logic [RAW_W-1:0] back_ring_reg  [HISTORY_LEN];
    logic [POS_W-1:0] pos_reg, pos_next, pos_base;
    logic             primed_reg;
    logic             valid_reg;
    logic [SUM_W-1:0] front_sum_reg, front_sum_next;
    logic [SUM_W-1:0] back_sum_reg, back_sum_next;
    logic [RAW_W-1:0] front_old, back_old;

    always_comb
    begin
        front_old = front_ring_reg[pos_reg];
        back_old  = back_ring_reg[pos_reg];
        pos_base  = primed_reg ? pos_reg : '0;
        pos_next  = (pos_base == LAST_POS) ? '0 : pos_base + 1'b1;
        if (!primed_reg)
        begin
            // first valid pair fills the whole ring
            front_sum_next = SUM_W'(front) * SUM_W'(HISTORY_LEN);
            back_sum_next  = SUM_W'(back) * SUM_W'(HISTORY_LEN);
        end
        else
        begin
            front_sum_next = front_sum_reg - SUM_W'(front_old) + SUM_W'(front);
            back_sum_next  = back_sum_reg - SUM_W'(back_old) + SUM_W'(back);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            primed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                pos_reg    <= pos_next;
                primed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            front_sum_reg <= front_sum_next;
            back_sum_reg  <= back_sum_next;
            for (int i = 0; i < HISTORY_LEN; i++)
            begin
                if (!primed_reg || POS_W'(i) == pos_reg)
                begin
                    front_ring_reg[i] <= front;
                    back_ring_reg[i]  <= back;
                end
            end
        end
    end

    assign sum_valid = valid_reg;
    assign front_sum = front_sum_reg;
    assign back_sum  = back_sum_reg;

endmodule

@@ sv/wfpd_pd.sv @@
// PD term: error, products, scaled division and saturation.
module wfpd_pd #(
    parameter int HISTORY_LEN = 5,
    parameter int CORRECTION_LIMIT = 50,
    parameter int SUM_W = $clog2(HISTORY_LEN * ((1 << wfpd_pkg::RAW_W) - 1) + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  wfpd_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    input  logic [SUM_W-1:0]               front_sum,
    input  logic [SUM_W-1:0]               back_sum,
    output logic                           pd_valid,
    output logic signed [wfpd_pkg::PD_W-1:0] pd
);
    import wfpd_pkg::*;

    localparam int EXT_W = SUM_W + 2;
    localparam int ERR_W = $clog2(HISTORY_LEN * 1023 + 1) + 1;
    localparam int DE_W  = ERR_W + 1;
    localparam int ANG_W = SUM_W + 1;
    localparam int NUM_W = SUM_W + 1 + GAIN_W + 1 + 2;
    localparam int M_W   = $clog2((CORRECTION_LIMIT + 1) * HISTORY_LEN);
    localparam int Q_W   = $clog2(CORRECTION_LIMIT + 1);
    localparam int RS    = M_W + 4;
    localparam int PW    = M_W + RS;
    localparam logic [PW-1:0] R_VAL = PW'((64'd1 << RS) / HISTORY_LEN);
    localparam logic [SUM_W-1:0] CF_MIN = SUM_W'(HISTORY_LEN * MIN_DIST);
    localparam logic [SUM_W-1:0] CF_MAX = SUM_W'(HISTORY_LEN * MAX_DIST);
    localparam logic signed [EXT_W-1:0] DB_POS = EXT_W'(HISTORY_LEN * DEADBAND);
    localparam logic signed [EXT_W-1:0] DB_NEG = -DB_POS;
    localparam logic [NUM_W-1:0] SAT_TH =
        NUM_W'((CORRECTION_LIMIT + 1) * HISTORY_LEN * (1 << SCALE_SH));

    // stage A: error, error change, angle
    logic [SUM_W-1:0]        cf, tgt_scaled;
    logic signed [EXT_W-1:0] e_wide, e_db;
    logic signed [ERR_W-1:0] err, err_reg, prev_error_reg;
    logic signed [DE_W-1:0]  de, de_reg;
    logic signed [ANG_W-1:0] ang, ang_reg;
    logic                    a_valid_reg;

    always_comb
    begin
        if (front_sum < CF_MIN)
            cf = CF_MIN;
        else if (front_sum > CF_MAX)
            cf = CF_MAX;
        else
            cf = front_sum;
        tgt_scaled = SUM_W'(cfg.target_distance) * SUM_W'(HISTORY_LEN);
        e_wide = signed'({2'b00, tgt_scaled}) - signed'({2'b00, cf});
        e_db   = (e_wide > DB_NEG && e_wide < DB_POS) ? '0 : e_wide;
        err    = ERR_W'(e_db);
        de     = DE_W'(err) - DE_W'(prev_error_reg);
        ang    = signed'({1'b0, front_sum}) - signed'({1'b0, back_sum});
    end

    // stage B: products
    logic signed [NUM_W-1:0] p_kp_reg, p_kd_reg, p_ka_reg;
    logic                    b_valid_reg;
    // stage C: numerator
    logic signed [NUM_W-1:0] num_reg;
    logic                    c_valid_reg;
    // stage D: magnitude and saturation
    logic [NUM_W-1:0]        mag;
    logic [M_W-1:0]          m_reg, m_d2_reg;
    logic                    neg_reg, neg_d2_reg, sat_reg, sat_d2_reg;
    logic                    d_valid_reg;
    // stage E: quotient estimate
    logic [Q_W-1:0]          q0, q0_reg;
    logic                    e_valid_reg;
    // stage F: correction and sign
    logic [M_W-1:0]          qn, rem;
    logic [Q_W-1:0]          q;
    logic [PD_W-1:0]         pd_mag;
    logic signed [PD_W-1:0]  pd_next, pd_reg;
    logic                    pd_valid_reg;

    always_comb
    begin
        mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        q0  = Q_W'((PW'(m_reg) * R_VAL) >> RS);
        // estimate is low by at most one
        qn  = M_W'(q0_reg) * M_W'(HISTORY_LEN);
        rem = m_d2_reg - qn;
        q   = (rem >= M_W'(HISTORY_LEN)) ? Q_W'(q0_reg + 1'b1) : q0_reg;
        pd_mag  = sat_d2_reg ? PD_W'(CORRECTION_LIMIT) : PD_W'(q);
        pd_next = neg_d2_reg ? -signed'(pd_mag) : signed'(pd_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            d_valid_reg    <= 1'b0;
            e_valid_reg    <= 1'b0;
            pd_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= in_valid;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            e_valid_reg  <= d_valid_reg;
            pd_valid_reg <= e_valid_reg;
            if (in_valid)
                prev_error_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg    <= err;
            de_reg     <= de;
            ang_reg    <= ang;
            p_kp_reg   <= NUM_W'(err_reg) * NUM_W'(signed'({1'b0, cfg.kp_gain}));
            p_kd_reg   <= NUM_W'(de_reg) * NUM_W'(signed'({1'b0, cfg.kd_gain}));
            p_ka_reg   <= NUM_W'(ang_reg) * NUM_W'(signed'({1'b0, cfg.angle_gain}));
            num_reg    <= p_kp_reg + p_kd_reg - p_ka_reg;
            neg_reg    <= num_reg[NUM_W-1];
            sat_reg    <= (mag >= SAT_TH);
            m_reg      <= M_W'(mag >> SCALE_SH);
            q0_reg     <= q0;
            m_d2_reg   <= m_reg;
            neg_d2_reg <= neg_reg;
            sat_d2_reg <= sat_reg;
            pd_reg     <= pd_next;
        end
    end

    assign pd_valid = pd_valid_reg;
    assign pd       = pd_reg;

endmodule
